// ===== rtl/ghp_pkg.sv =====
package ghp_pkg;

  localparam int ByteW   = 8;
  localparam int StatusW = 3;
  localparam int PhaseW  = 4;
  localparam int CountW  = 5;
  localparam int SkipW   = 16;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [StatusW-1:0] status_t;

  // status codes
  localparam status_t ST_OK          = 3'd0;
  localparam status_t ST_BAD_MAGIC   = 3'd1;
  localparam status_t ST_BAD_METHOD  = 3'd2;
  localparam status_t ST_NAME_CUT    = 3'd3;
  localparam status_t ST_COMMENT_CUT = 3'd4;
  localparam status_t ST_HEADER_CUT  = 3'd5;

  // one result beat
  typedef struct packed {
    byte_t   out_byte;
    logic    is_payload;
    logic    done_res;
    status_t status;
  } ghp_res_t;

endpackage

// ===== rtl/ghp_in_if.sv =====
interface ghp_in_if;
  logic           valid;
  logic           ready;
  ghp_pkg::byte_t data_byte;
  logic           last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// ===== rtl/ghp_out_if.sv =====
interface ghp_out_if;
  logic             valid;
  logic             ready;
  ghp_pkg::byte_t   out_byte;
  logic             is_payload;
  logic             done_res;
  ghp_pkg::status_t status;

  modport source (output valid, output out_byte, output is_payload, output done_res,
                  output status, input ready);
  modport sink   (input valid, input out_byte, input is_payload, input done_res,
                  input status, output ready);
endinterface

// ===== rtl/ghp_core.sv =====
module ghp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  ghp_pkg::byte_t    data_byte,
  input  logic              last,
  output ghp_pkg::ghp_res_t res
);
  import ghp_pkg::*;

  localparam logic [PhaseW-1:0] PH_MAGIC0  = 4'd0;
  localparam logic [PhaseW-1:0] PH_MAGIC1  = 4'd1;
  localparam logic [PhaseW-1:0] PH_METHOD  = 4'd2;
  localparam logic [PhaseW-1:0] PH_FLAGS   = 4'd3;
  localparam logic [PhaseW-1:0] PH_FIXED   = 4'd4;
  localparam logic [PhaseW-1:0] PH_XLEN0   = 4'd5;
  localparam logic [PhaseW-1:0] PH_XLEN1   = 4'd6;
  localparam logic [PhaseW-1:0] PH_EXTRA   = 4'd7;
  localparam logic [PhaseW-1:0] PH_NAME    = 4'd8;
  localparam logic [PhaseW-1:0] PH_COMMENT = 4'd9;
  localparam logic [PhaseW-1:0] PH_HCRC    = 4'd10;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 4'd11;
  localparam logic [PhaseW-1:0] PH_DEAD    = 4'd12;

  localparam byte_t MAGIC0     = 8'h1f;
  localparam byte_t MAGIC1     = 8'h8b;
  localparam byte_t METHOD_DEF = 8'd8;

  localparam int FL_FHCRC    = 1;
  localparam int FL_FEXTRA   = 2;
  localparam int FL_FNAME    = 3;
  localparam int FL_FCOMMENT = 4;

  localparam logic [CountW-1:0] MIN_LEN   = CountW'(18);
  localparam logic [CountW-1:0] FIXED_LEN = CountW'(10);
  localparam logic [SkipW-1:0]  HCRC_LEN  = SkipW'(2);

  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [CountW-1:0] count_r, count_inc;
  byte_t             flags_r, flags_nxt;
  logic [SkipW-1:0]  skip_r, skip_nxt;
  byte_t             xlen_lo_r, xlen_lo_nxt;
  status_t           err_r, err_nxt;
  logic              payload;
  status_t           status;

  // section after the one just left
  function automatic logic [PhaseW-1:0] next_section(input logic [PhaseW-1:0] stage,
                                                     input byte_t flags);
    logic [PhaseW-1:0] ns;
    if (stage < PH_NAME && flags[FL_FNAME]) begin
      ns = PH_NAME;
    end else if (stage < PH_COMMENT && flags[FL_FCOMMENT]) begin
      ns = PH_COMMENT;
    end else if (stage < PH_HCRC && flags[FL_FHCRC]) begin
      ns = PH_HCRC;
    end else begin
      ns = PH_PAYLOAD;
    end
    return ns;
  endfunction

  always_comb begin
    count_inc   = (count_r < MIN_LEN) ? count_r + CountW'(1) : count_r;
    phase_nxt   = phase_r;
    flags_nxt   = flags_r;
    skip_nxt    = skip_r;
    xlen_lo_nxt = xlen_lo_r;
    err_nxt     = err_r;
    payload     = 1'b0;

    unique case (phase_r)
      PH_MAGIC0: begin
        if (data_byte != MAGIC0) begin
          err_nxt   = ST_BAD_MAGIC;
          phase_nxt = PH_DEAD;
        end else begin
          phase_nxt = PH_MAGIC1;
        end
      end
      PH_MAGIC1: begin
        if (data_byte != MAGIC1) begin
          err_nxt   = ST_BAD_MAGIC;
          phase_nxt = PH_DEAD;
        end else begin
          phase_nxt = PH_METHOD;
        end
      end
      PH_METHOD: begin
        if (data_byte != METHOD_DEF) begin
          err_nxt   = ST_BAD_METHOD;
          phase_nxt = PH_DEAD;
        end else begin
          phase_nxt = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        flags_nxt = data_byte;
        phase_nxt = PH_FIXED;
      end
      PH_FIXED: begin
        if (count_inc >= FIXED_LEN) begin
          phase_nxt = flags_r[FL_FEXTRA] ? PH_XLEN0 : next_section(PH_EXTRA, flags_r);
        end
      end
      PH_XLEN0: begin
        xlen_lo_nxt = data_byte;
        phase_nxt   = PH_XLEN1;
      end
      PH_XLEN1: begin
        skip_nxt  = {data_byte, xlen_lo_r};
        phase_nxt = (skip_nxt != '0) ? PH_EXTRA : next_section(PH_EXTRA, flags_r);
      end
      PH_EXTRA: begin
        skip_nxt = skip_r - SkipW'(1);
        if (skip_nxt == '0) begin
          phase_nxt = next_section(PH_EXTRA, flags_r);
        end
      end
      PH_NAME: begin
        if (data_byte == '0) begin
          phase_nxt = next_section(PH_NAME, flags_r);
        end
      end
      PH_COMMENT: begin
        if (data_byte == '0) begin
          phase_nxt = next_section(PH_COMMENT, flags_r);
        end
      end
      PH_HCRC: begin
        skip_nxt = skip_r - SkipW'(1);
        if (skip_nxt == '0) begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        payload = 1'b1;
      end
      default: begin
        phase_nxt = PH_DEAD;
      end
    endcase

    // entering the crc section loads its length
    if (phase_nxt == PH_HCRC && phase_r != PH_HCRC) begin
      skip_nxt = HCRC_LEN;
    end
  end

  always_comb begin
    status = ST_OK;
    if (last) begin
      priority if (count_inc < MIN_LEN) begin
        status = ST_BAD_MAGIC;
      end else if (err_nxt != ST_OK) begin
        status = err_nxt;
      end else if (payload) begin
        status = ST_OK;
      end else if (phase_nxt == PH_EXTRA) begin
        status = flags_nxt[FL_FNAME] ? ST_NAME_CUT :
                 (flags_nxt[FL_FCOMMENT] ? ST_COMMENT_CUT : ST_HEADER_CUT);
      end else if (phase_nxt == PH_NAME) begin
        status = ST_NAME_CUT;
      end else if (phase_nxt == PH_COMMENT) begin
        status = ST_COMMENT_CUT;
      end else begin
        status = ST_HEADER_CUT;
      end
    end
  end

  assign res.out_byte   = data_byte;
  assign res.is_payload = payload;
  assign res.done_res   = last;
  assign res.status     = status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_MAGIC0;
      count_r   <= '0;
      flags_r   <= '0;
      skip_r    <= '0;
      xlen_lo_r <= '0;
      err_r     <= ST_OK;
    end else if (accept) begin
      if (last) begin
        phase_r   <= PH_MAGIC0;
        count_r   <= '0;
        flags_r   <= '0;
        skip_r    <= '0;
        xlen_lo_r <= '0;
        err_r     <= ST_OK;
      end else begin
        phase_r   <= phase_nxt;
        count_r   <= count_inc;
        flags_r   <= flags_nxt;
        skip_r    <= skip_nxt;
        xlen_lo_r <= xlen_lo_nxt;
        err_r     <= err_nxt;
      end
    end
  end

endmodule

// ===== rtl/ghp_out_reg.sv =====
module ghp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  ghp_pkg::ghp_res_t res_in,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output ghp_pkg::ghp_res_t res_out
);
  import ghp_pkg::*;

  logic     valid_r;
  ghp_res_t res_r;

  // a new beat may enter while the held one leaves
  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

// ===== rtl/gzip_header_parser.sv =====
// gzip member header parser
// in_ch carries the file one byte per beat (data_byte, last on the final byte).
// out_ch returns exactly one beat per input beat: the byte passed through,
// is_payload for bytes past the header (deflate data and footer), and on the
// final byte done_res with the status code (ok, bad magic or short file, bad
// method, name cut, comment cut, header cut).
// each result beat is held in the output register, valid in the cycle after its input beat is accepted.
// throughput: one byte per cycle while out_ch is not stalled; the header phase logic
// feeding the result register sets the rate.
// stall: while out_ch is stalled with a result held, in_ch.ready drops; it is
// high whenever the output register is empty or being drained this cycle.
// reset: rst_n (synchronous, active low) empties the result register and puts the
// parser at the first magic byte; after every final byte the parser rearms there too.
// payload beats that precede a failing status are to be dropped downstream.
module gzip_header_parser (
  input  logic      clk,
  input  logic      rst_n,
  ghp_in_if.sink    in_ch,
  ghp_out_if.source out_ch
);
  import ghp_pkg::*;

  logic     accept;
  logic     can_load;
  ghp_res_t res_comb;
  ghp_res_t res_held;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  // header phase tracking and per-byte result
  ghp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_ch.data_byte),
    .last      (in_ch.last),
    .res       (res_comb)
  );

  // result register toward the consumer
  ghp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res_in    (res_comb),
    .can_load  (can_load),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .res_out   (res_held)
  );

  assign out_ch.out_byte   = res_held.out_byte;
  assign out_ch.is_payload = res_held.is_payload;
  assign out_ch.done_res   = res_held.done_res;
  assign out_ch.status     = res_held.status;

endmodule

// ===== verif/gzip_header_parser_test.sv =====
`timescale 1ns / 100ps

import ghp_pkg::*;

// gzip header fields
localparam byte_t GZ_ID1         = 8'h1f;
localparam byte_t GZ_ID2         = 8'h8b;
localparam byte_t GZ_CM_DEFLATE  = 8'd8;
localparam byte_t GZ_FLG_HCRC    = 8'h02;
localparam byte_t GZ_FLG_EXTRA   = 8'h04;
localparam byte_t GZ_FLG_NAME    = 8'h08;
localparam byte_t GZ_FLG_COMMENT = 8'h10;
localparam int    GZ_MIN_BYTES   = 18;
localparam int    GZ_FIXED_BYTES = 10;

typedef enum logic [3:0] {
  SEC_ID1, SEC_ID2, SEC_CM, SEC_FLG, SEC_FIXED, SEC_XLEN_LO, SEC_XLEN_HI,
  SEC_EXTRA, SEC_FNAME, SEC_FCOMMENT, SEC_FHCRC, SEC_DATA, SEC_SINK
} hdr_sec_e;

// tracks the header walk and holds the result beats still to come
class gzip_stream_tracker;
  hdr_sec_e    sec;
  logic [4:0]  seen;
  byte_t       flags;
  logic [15:0] skip;
  byte_t       xlen_lo;
  status_t     err;
  ghp_res_t    expected_beats[$];
  int          mismatches;

  function new();
    mismatches = 0;
    rearm();
  endfunction

  function void rearm();
    sec     = SEC_ID1;
    seen    = '0;
    flags   = '0;
    skip    = '0;
    xlen_lo = '0;
    err     = ST_OK;
  endfunction

  // section that follows the one just left
  function hdr_sec_e after_section(hdr_sec_e left);
    if (left < SEC_FNAME && (flags & GZ_FLG_NAME) != 0) return SEC_FNAME;
    if (left < SEC_FCOMMENT && (flags & GZ_FLG_COMMENT) != 0) return SEC_FCOMMENT;
    if (left < SEC_FHCRC && (flags & GZ_FLG_HCRC) != 0) begin
      skip = 16'd2;
      return SEC_FHCRC;
    end
    return SEC_DATA;
  endfunction

  function void note_byte(byte_t b, logic fin);
    ghp_res_t r;
    logic     pay;
    status_t  st;
    pay = 1'b0;
    st  = ST_OK;
    if (seen < GZ_MIN_BYTES) seen++;
    case (sec)
      SEC_ID1: begin
        if (b != GZ_ID1) begin
          err = ST_BAD_MAGIC;
          sec = SEC_SINK;
        end else sec = SEC_ID2;
      end
      SEC_ID2: begin
        if (b != GZ_ID2) begin
          err = ST_BAD_MAGIC;
          sec = SEC_SINK;
        end else sec = SEC_CM;
      end
      SEC_CM: begin
        if (b != GZ_CM_DEFLATE) begin
          err = ST_BAD_METHOD;
          sec = SEC_SINK;
        end else sec = SEC_FLG;
      end
      SEC_FLG: begin
        flags = b;
        sec   = SEC_FIXED;
      end
      SEC_FIXED: begin
        if (seen >= GZ_FIXED_BYTES)
          sec = ((flags & GZ_FLG_EXTRA) != 0) ? SEC_XLEN_LO : after_section(SEC_EXTRA);
      end
      SEC_XLEN_LO: begin
        xlen_lo = b;
        sec     = SEC_XLEN_HI;
      end
      SEC_XLEN_HI: begin
        skip = {b, xlen_lo};
        sec  = (skip != 0) ? SEC_EXTRA : after_section(SEC_EXTRA);
      end
      SEC_EXTRA: begin
        skip = skip - 16'd1;
        if (skip == 0) sec = after_section(SEC_EXTRA);
      end
      SEC_FNAME: begin
        if (b == 8'h00) sec = after_section(SEC_FNAME);
      end
      SEC_FCOMMENT: begin
        if (b == 8'h00) sec = after_section(SEC_FCOMMENT);
      end
      SEC_FHCRC: begin
        skip = skip - 16'd1;
        if (skip == 0) sec = SEC_DATA;
      end
      SEC_DATA: pay = 1'b1;
      default:  sec = SEC_SINK;
    endcase

    if (fin) begin
      if (seen < GZ_MIN_BYTES) st = ST_BAD_MAGIC;
      else if (err != ST_OK) st = err;
      else if (pay) st = ST_OK;
      else if (sec == SEC_EXTRA) begin
        if ((flags & GZ_FLG_NAME) != 0) st = ST_NAME_CUT;
        else if ((flags & GZ_FLG_COMMENT) != 0) st = ST_COMMENT_CUT;
        else st = ST_HEADER_CUT;
      end
      else if (sec == SEC_FNAME) st = ST_NAME_CUT;
      else if (sec == SEC_FCOMMENT) st = ST_COMMENT_CUT;
      else st = ST_HEADER_CUT;
    end

    r.out_byte   = b;
    r.is_payload = pay;
    r.done_res   = fin;
    r.status     = st;
    expected_beats.push_back(r);
    if (fin) rearm();
  endfunction

  task report_mismatch(string what);
    if (mismatches < 100) $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  task check_beat(byte_t ob, logic pl, logic dn, status_t st);
    ghp_res_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("result beat 0x%02h with nothing expected", ob));
      return;
    end
    want = expected_beats.pop_front();
    if (ob !== want.out_byte)
      report_mismatch($sformatf("out_byte 0x%02h, want 0x%02h", ob, want.out_byte));
    if (pl !== want.is_payload)
      report_mismatch($sformatf("is_payload %b, want %b (byte 0x%02h)", pl, want.is_payload,
                                want.out_byte));
    if (dn !== want.done_res)
      report_mismatch($sformatf("done_res %b, want %b (byte 0x%02h)", dn, want.done_res,
                                want.out_byte));
    if (st !== want.status)
      report_mismatch($sformatf("status %0d, want %0d (byte 0x%02h)", st, want.status,
                                want.out_byte));
  endtask
endclass

module gzip_header_parser_test;

  logic clk;
  logic rst_n;

  ghp_in_if  in_ch();
  ghp_out_if out_ch();

  gzip_header_parser uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gzip_stream_tracker tracker;

  byte_t file_bytes[$];   // file under construction
  int    sent;            // beats accepted so far
  bit    allow_gaps;      // random idling on both sides
  int    hold_request;    // cycles of long receiver hold-off, picked up by the sink side

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // plain header with the given optional sections, then data_len bytes of payload
  task automatic build_file(input byte_t flg, input int xlen, input int fname_len,
                            input int cmt_len, input int data_len);
    file_bytes.delete();
    file_bytes.push_back(GZ_ID1);
    file_bytes.push_back(GZ_ID2);
    file_bytes.push_back(GZ_CM_DEFLATE);
    file_bytes.push_back(flg);
    // mtime, xfl, os
    repeat (6) file_bytes.push_back(byte_t'($urandom_range(0, 255)));
    if ((flg & GZ_FLG_EXTRA) != 0) begin
      file_bytes.push_back(xlen[7:0]);
      file_bytes.push_back(xlen[15:8]);
      repeat (xlen) file_bytes.push_back(byte_t'($urandom_range(0, 255)));
    end
    if ((flg & GZ_FLG_NAME) != 0) begin
      repeat (fname_len) file_bytes.push_back(byte_t'($urandom_range(1, 255)));
      file_bytes.push_back(8'h00);
    end
    if ((flg & GZ_FLG_COMMENT) != 0) begin
      repeat (cmt_len) file_bytes.push_back(byte_t'($urandom_range(1, 255)));
      file_bytes.push_back(8'h00);
    end
    if ((flg & GZ_FLG_HCRC) != 0)
      repeat (2) file_bytes.push_back(byte_t'($urandom_range(0, 255)));
    repeat (data_len) file_bytes.push_back(byte_t'($urandom_range(0, 255)));
  endtask

  // drop bytes so the file ends after n bytes
  task automatic cut_to(input int n);
    while (file_bytes.size() > n) void'(file_bytes.pop_back());
  endtask

  // flip some bits so the byte no longer matches
  task automatic corrupt(input int idx);
    file_bytes[idx] = file_bytes[idx] ^ byte_t'($urandom_range(1, 255));
  endtask

  // one beat; an idle gap lowers valid first, otherwise valid stays up
  task automatic send_beat(input byte_t b, input logic fin);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last      <= fin;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_byte(b, fin);
    sent++;
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_beat(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  // sink side: check every accepted beat, then pick ready for the next cycle
  initial begin : sink_side
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        tracker.check_beat(out_ch.out_byte, out_ch.is_payload, out_ch.done_res, out_ch.status);
      if (hold_request > 0) begin
        // long hold-off so the output register fills and input stalls
        stall_left   = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && allow_gaps && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : source_side
    int  kind;
    int  xlen;
    bit  second_hold;
    byte_t flg;
    tracker      = new();
    sent         = 0;
    allow_gaps   = 1'b1;
    hold_request = 0;
    second_hold  = 1'b0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last      <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed files ----
    // single byte file, too short
    file_bytes.delete();
    file_bytes.push_back(GZ_ID1);
    send_file();
    // smallest good file, payload bytes at both extremes
    build_file(8'h00, 0, 0, 0, 8);
    file_bytes[16] = 8'h00;
    file_bytes[17] = 8'hff;
    send_file();
    // good header but one byte short of the minimum
    build_file(8'h00, 0, 0, 0, 7);
    send_file();
    // bad first and second magic byte
    build_file(8'h00, 0, 0, 0, 10);
    corrupt(0);
    send_file();
    build_file(8'h00, 0, 0, 0, 10);
    corrupt(1);
    send_file();
    // bad method
    build_file(8'h00, 0, 0, 0, 10);
    corrupt(2);
    send_file();
    // bad method in a short file: short wins
    build_file(8'h00, 0, 0, 0, 10);
    corrupt(2);
    cut_to(3);
    send_file();
    // data ends inside extra field: name, then comment, then neither pending
    build_file(GZ_FLG_EXTRA | GZ_FLG_NAME | GZ_FLG_COMMENT | GZ_FLG_HCRC, 12, 3, 3, 4);
    cut_to(18);
    send_file();
    build_file(GZ_FLG_EXTRA | GZ_FLG_COMMENT, 12, 0, 3, 4);
    cut_to(18);
    send_file();
    build_file(GZ_FLG_EXTRA, 12, 0, 0, 4);
    cut_to(18);
    send_file();
    // name cut, comment cut
    build_file(GZ_FLG_NAME, 0, 12, 0, 4);
    cut_to(18);
    send_file();
    build_file(GZ_FLG_COMMENT, 0, 0, 12, 4);
    cut_to(18);
    send_file();
    // ends right on the name terminator: comment pending, crc pending, empty payload
    build_file(GZ_FLG_NAME | GZ_FLG_COMMENT, 0, 8, 5, 4);
    cut_to(19);
    send_file();
    build_file(GZ_FLG_NAME | GZ_FLG_HCRC, 0, 8, 0, 4);
    cut_to(19);
    send_file();
    build_file(GZ_FLG_NAME, 0, 9, 0, 0);
    send_file();
    // zero length extra field
    build_file(GZ_FLG_EXTRA, 0, 0, 0, 8);
    send_file();
    // header crc only
    build_file(GZ_FLG_HCRC, 0, 0, 0, 6);
    send_file();
    // every flag set, reserved bits too
    build_file(8'hff, 5, 2, 2, 4);
    send_file();
    // extra length with the high byte in use
    build_file(GZ_FLG_EXTRA, 260, 0, 0, 3);
    send_file();
    // ends between the two crc bytes
    build_file(GZ_FLG_EXTRA | GZ_FLG_HCRC, 8, 0, 0, 4);
    cut_to(21);
    send_file();

    // ---- random files, mostly well formed ----
    hold_request = 150;
    while (sent < 1600) begin
      if (sent >= 1350) allow_gaps = 1'b0;
      else allow_gaps = ($urandom_range(0, 4) != 0);
      if (!second_hold && sent >= 900) begin
        hold_request = 200;
        second_hold  = 1'b1;
      end
      flg  = byte_t'($urandom_range(0, 255));
      xlen = ($urandom_range(0, 39) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 6);
      build_file(flg, xlen, $urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 16));
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        // complete file
      end else if (kind < 80) begin
        cut_to($urandom_range(1, file_bytes.size()));
      end else if (kind < 87) begin
        corrupt($urandom_range(0, 1));
      end else if (kind < 92) begin
        corrupt(2);
      end else begin
        // noise
        file_bytes.delete();
        repeat ($urandom_range(1, 30)) file_bytes.push_back(byte_t'($urandom_range(0, 255)));
      end
      send_file();
    end

    // drain
    in_ch.valid <= 1'b0;
    allow_gaps  = 1'b0;
    while (tracker.expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
